// ===== rtl/fps_pkg.sv =====
// Shared types and constants for the footswitch preset selector.
`default_nettype none

package fps_pkg;

  // Control state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WAIT1 = 3'b010,
    ST_WAIT2 = 3'b100
  } ctrl_state_e;

  // Configuration register indexes
  localparam logic [1:0] REG_MODE_SELECT   = 2'd0;
  localparam logic [1:0] REG_RELEASE_TICKS = 2'd1;
  localparam logic [1:0] REG_PROGRAM_LIMIT = 2'd2;
  localparam logic [1:0] REG_BANK_LIMIT    = 2'd3;

  // Mode codes
  localparam logic MODE_DUAL = 1'b0;
  localparam logic MODE_QUAD = 1'b1;

  // Banked-mode chords
  localparam logic [3:0] CHORD_BANK_DOWN = 4'h3;
  localparam logic [3:0] CHORD_BANK_UP   = 4'hC;

  // Reset values of the configuration
  localparam logic [7:0] RELEASE_TICKS_RST = 8'd5;
  localparam logic [6:0] PROGRAM_LIMIT_RST = 7'd20;
  localparam logic [4:0] BANK_LIMIT_RST    = 5'd5;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic       mode_select;
    logic [7:0] release_ticks;
    logic [6:0] program_limit;
    logic [4:0] bank_limit;
  } cfg_t;

  typedef struct packed {
    ctrl_state_e ctrl;
    logic [7:0]  release_count;
    logic [6:0]  current_program;
    logic [4:0]  bank_num;
    logic [3:0]  pending_mask;
  } sel_state_t;

endpackage

`default_nettype wire

// ===== rtl/fps_step.sv =====
// Next-state and result logic for one switch sample.
`default_nettype none

module fps_step (
  input  var fps_pkg::cfg_t       cfg_i,
  input  var fps_pkg::sel_state_t state_i,
  input  wire logic [3:0]         pressed_i,
  output fps_pkg::sel_state_t     state_o,
  output logic                    emit_o,
  output logic [6:0]              program_o
);

  logic       released;
  logic [7:0] count_inc;

  // Released test for the switch being waited on in dual mode
  always_comb begin
    released = 1'b0;
    case (state_i.ctrl)
      fps_pkg::ST_WAIT1: released = ~pressed_i[0];
      fps_pkg::ST_WAIT2: released = ~pressed_i[1];
      default:           released = 1'b0;
    endcase
  end

  // Saturating release counter
  assign count_inc = (state_i.release_count == fps_pkg::COUNT_MAX) ?
                     state_i.release_count : state_i.release_count + 8'd1;

  always_comb begin
    state_o   = state_i;
    emit_o    = 1'b0;
    program_o = state_i.current_program;

    if (cfg_i.mode_select == fps_pkg::MODE_DUAL) begin
      if (state_i.ctrl != fps_pkg::ST_IDLE) begin
        // waiting for the switch to stay released
        if (released) begin
          state_o.release_count = count_inc;
          if (count_inc >= cfg_i.release_ticks) begin
            state_o.ctrl = fps_pkg::ST_IDLE;
          end
        end else begin
          state_o.release_count = '0;
        end
      end else if (pressed_i[0]) begin
        // step down, switch 1 wins over switch 2
        if (state_i.current_program != 7'd0) begin
          state_o.current_program = state_i.current_program - 7'd1;
          program_o               = state_i.current_program - 7'd1;
          emit_o                  = 1'b1;
        end
        state_o.release_count = '0;
        state_o.ctrl          = fps_pkg::ST_WAIT1;
      end else if (pressed_i[1]) begin
        // step up while below the limit
        if (state_i.current_program < cfg_i.program_limit) begin
          state_o.current_program = state_i.current_program + 7'd1;
          program_o               = state_i.current_program + 7'd1;
          emit_o                  = 1'b1;
        end
        state_o.release_count = '0;
        state_o.ctrl          = fps_pkg::ST_WAIT2;
      end
    end else begin
      if (state_i.ctrl != fps_pkg::ST_IDLE) begin
        // banked wait ends once everything is released
        if (pressed_i == 4'd0) begin
          state_o.ctrl         = fps_pkg::ST_IDLE;
          state_o.pending_mask = '0;
        end
      end else if (pressed_i != 4'd0) begin
        if (pressed_i == fps_pkg::CHORD_BANK_DOWN) begin
          if (state_i.bank_num != 5'd0) begin
            state_o.bank_num = state_i.bank_num - 5'd1;
          end
          state_o.ctrl = fps_pkg::ST_WAIT1;
        end else if (pressed_i == fps_pkg::CHORD_BANK_UP) begin
          if (state_i.bank_num < cfg_i.bank_limit) begin
            state_o.bank_num = state_i.bank_num + 5'd1;
          end
          state_o.ctrl = fps_pkg::ST_WAIT1;
        end else begin
          state_o.pending_mask = pressed_i;
        end
      end else if (state_i.pending_mask != 4'd0) begin
        // all released: bank * 4 plus lowest pressed switch
        emit_o = 1'b1;
        if (state_i.pending_mask[0]) begin
          program_o = {state_i.bank_num, 2'd0};
        end else if (state_i.pending_mask[1]) begin
          program_o = {state_i.bank_num, 2'd1};
        end else if (state_i.pending_mask[2]) begin
          program_o = {state_i.bank_num, 2'd2};
        end else begin
          program_o = {state_i.bank_num, 2'd3};
        end
        state_o.pending_mask = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/footswitch_preset_selector.sv =====
// Top level of the footswitch preset selector: stream ports, registers, config.
//
// One switch sample per word on the input stream; each sample is taken into an
// input register and processed by the next-state logic once the output slot is
// free, and any program-change number lands in an output register. A new word
// can be accepted every cycle (1 word per clock sustained) while the output is
// not stalled; the rate is set by the single registered state update per
// sample. Most samples give no result word. The configuration port writes
// registers 0..3 (mode, release ticks, program limit, bank limit) and should
// only be used while the block is idle.
`default_nettype none

module footswitch_preset_selector (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [3:0] switch_levels, [7:4] zero
  // Output stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [6:0] program_number, [7] zero
  // Configuration write port
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_addr_i,
  input  wire logic [7:0] cfg_wdata_i
);

  fps_pkg::cfg_t       cfg_q;
  fps_pkg::sel_state_t state_q, state_d;
  logic                in_valid_q;
  logic [3:0]          pressed_q;
  logic                out_valid_q;
  logic [6:0]          out_prog_q;
  logic                out_free;
  logic                process;
  logic                emit;
  logic [6:0]          prog;

  // Handshake: a held sample is processed whenever the output slot can take it
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign process         = in_valid_q & out_free;
  assign s_axis_tready_o = ~in_valid_q | process;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_select   <= fps_pkg::MODE_DUAL;
      cfg_q.release_ticks <= fps_pkg::RELEASE_TICKS_RST;
      cfg_q.program_limit <= fps_pkg::PROGRAM_LIMIT_RST;
      cfg_q.bank_limit    <= fps_pkg::BANK_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fps_pkg::REG_MODE_SELECT:   cfg_q.mode_select   <= cfg_wdata_i[0];
        fps_pkg::REG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_wdata_i;
        fps_pkg::REG_PROGRAM_LIMIT: cfg_q.program_limit <= cfg_wdata_i[6:0];
        fps_pkg::REG_BANK_LIMIT:    cfg_q.bank_limit    <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  // Input register, stores the active-high pressed mask
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      pressed_q <= ~s_axis_tdata_i[3:0];
    end
  end

  fps_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .pressed_i (pressed_q),
    .state_o   (state_d),
    .emit_o    (emit),
    .program_o (prog)
  );

  // Selector state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.ctrl            <= fps_pkg::ST_IDLE;
      state_q.release_count   <= '0;
      state_q.current_program <= '0;
      state_q.bank_num        <= '0;
      state_q.pending_mask    <= '0;
    end else if (process) begin
      state_q <= state_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= process & emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emit) begin
      out_prog_q <= prog;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_prog_q};

endmodule

`default_nettype wire

// ===== sim/footswitch_preset_selector_checker.sv =====
// Checker for the footswitch preset selector: predicts program numbers and compares results.
module footswitch_preset_selector_checker
  import fps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream, observed
  input  logic       s_valid_i,
  input  logic       s_ready_i,
  input  logic [7:0] s_data_i,   // [3:0] switch_levels, [7:4] zero
  // Output stream, observed
  input  logic       m_valid_i,
  input  logic       m_ready_i,
  input  logic [7:0] m_data_i,   // [6:0] program_number, [7] zero
  // Configuration writes, observed
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_addr_i,
  input  logic [7:0] cfg_wdata_i,
  // Status for the testbench top
  output int         pending_o,
  output int         errors_o,
  output int         programs_seen_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Own copy of configuration and selector state
  cfg_t        cfg;
  ctrl_state_e ctrl       = ST_IDLE;
  logic [7:0]  rel_cnt    = '0;
  logic [6:0]  prog       = '0;
  logic [4:0]  bank       = '0;
  logic [3:0]  held_mask  = '0;

  // Program numbers still owed by the block, oldest first
  logic [6:0]  program_q[$];

  initial begin
    errors_o        = 0;
    programs_seen_o = 0;
    pending_o       = 0;
  end

  // Count consecutive released samples while waiting in two-switch mode
  task automatic track_release(input logic released);
    if (released) begin
      if (rel_cnt != COUNT_MAX) rel_cnt++;
      if (rel_cnt >= cfg.release_ticks) ctrl = ST_IDLE;
    end else begin
      rel_cnt = '0;
    end
  endtask

  // Two-switch up/down stepping
  task automatic step_program(input logic [3:0] pressed);
    if (ctrl == ST_WAIT1) begin
      track_release(!pressed[0]);
    end else if (ctrl == ST_WAIT2) begin
      track_release(!pressed[1]);
    end else if (pressed[0]) begin
      // switch 1 wins when both are down
      if (prog != '0) begin
        prog--;
        program_q.push_back(prog);
      end
      rel_cnt = '0;
      ctrl    = ST_WAIT1;
    end else if (pressed[1]) begin
      if (prog < cfg.program_limit) begin
        prog++;
        program_q.push_back(prog);
      end
      rel_cnt = '0;
      ctrl    = ST_WAIT2;
    end
  endtask

  // Four-switch banked selection
  task automatic select_banked(input logic [3:0] pressed);
    logic [1:0] idx;
    if (ctrl != ST_IDLE) begin
      // any wait ends on all released, dropping the held pattern
      if (pressed == '0) begin
        ctrl      = ST_IDLE;
        held_mask = '0;
      end
    end else if (pressed != '0) begin
      if (pressed == CHORD_BANK_DOWN) begin
        if (bank != '0) bank--;
        ctrl = ST_WAIT1;
      end else if (pressed == CHORD_BANK_UP) begin
        if (bank < cfg.bank_limit) bank++;
        ctrl = ST_WAIT1;
      end else begin
        held_mask = pressed;
      end
    end else if (held_mask != '0) begin
      // lowest pressed switch picks the slot within the bank
      if (held_mask[0])      idx = 2'd0;
      else if (held_mask[1]) idx = 2'd1;
      else if (held_mask[2]) idx = 2'd2;
      else                   idx = 2'd3;
      program_q.push_back({bank, idx});
      held_mask = '0;
    end
  endtask

  // Watch all three ports on each edge
  always @(posedge clk_i or negedge rst_ni) begin
    logic [6:0] exp_prog;
    if (!rst_ni) begin
      cfg.mode_select   = MODE_DUAL;
      cfg.release_ticks = RELEASE_TICKS_RST;
      cfg.program_limit = PROGRAM_LIMIT_RST;
      cfg.bank_limit    = BANK_LIMIT_RST;
      ctrl      = ST_IDLE;
      rel_cnt   = '0;
      prog      = '0;
      bank      = '0;
      held_mask = '0;
      program_q.delete();
    end else begin
      // result word first, so a stray word is never matched to a fresh expectation
      if (m_valid_i && m_ready_i) begin
        programs_seen_o++;
        if (program_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %0d",
                   $time, m_data_i);
          errors_o++;
        end else begin
          exp_prog = program_q.pop_front();
          if (m_data_i !== {1'b0, exp_prog}) begin
            $display("%0t: program number mismatch, expected %0d, got %0d",
                     $time, {1'b0, exp_prog}, m_data_i);
            errors_o++;
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (cfg.mode_select == MODE_QUAD) select_banked(~s_data_i[3:0]);
        else                              step_program(~s_data_i[3:0]);
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MODE_SELECT:   cfg.mode_select   = cfg_wdata_i[0];
          REG_RELEASE_TICKS: cfg.release_ticks = cfg_wdata_i;
          REG_PROGRAM_LIMIT: cfg.program_limit = cfg_wdata_i[6:0];
          REG_BANK_LIMIT:    cfg.bank_limit    = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
    pending_o = program_q.size();
  end

endmodule

// ===== sim/footswitch_preset_selector_tb.sv =====
// Testbench top for the footswitch preset selector: stimulus, stalls and verdict.
module footswitch_preset_selector_tb;

  import fps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i  = 8'hFF;   // [3:0] switch_levels, [7:4] zero
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;            // [6:0] program_number, [7] zero
  logic       cfg_we_i        = 1'b0;
  logic [1:0] cfg_addr_i      = REG_MODE_SELECT;
  logic [7:0] cfg_wdata_i     = '0;

  int pending;
  int errors;
  int programs_seen;

  int burst_left    = 0;
  int cur_ticks     = RELEASE_TICKS_RST;
  int samples_sent  = 0;
  int settings_used = 1;

  footswitch_preset_selector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  footswitch_preset_selector_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_valid_i       (s_axis_tvalid_i),
    .s_ready_i       (s_axis_tready_o),
    .s_data_i        (s_axis_tdata_i),
    .m_valid_i       (m_axis_tvalid_o),
    .m_ready_i       (m_axis_tready_i),
    .m_data_i        (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pending_o       (pending),
    .errors_o        (errors),
    .programs_seen_o (programs_seen)
  );

  // 12 ns clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver back-pressure in one of four stall styles, re-chosen at random
  typedef enum logic [1:0] {
    RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_COIN
  } rdy_style_e;

  rdy_style_e  rdy_style = RDY_ALWAYS;
  int unsigned rdy_cycle = 0;

  always @(posedge clk_i) begin
    rdy_cycle <= rdy_cycle + 1;
    if (rdy_cycle % 50 == 0) rdy_style <= rdy_style_e'($urandom_range(0, 3));
    case (rdy_style)
      RDY_ALWAYS: m_axis_tready_i <= 1'b1;
      RDY_MOSTLY: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      RDY_SPARSE: m_axis_tready_i <= (rdy_cycle % 5 < 2);
      default:    m_axis_tready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // Send one switch sample; bursts of random length with optional gaps between
  task automatic send_word(input logic [3:0] levels);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 9) < 6) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, levels};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // Stop sending, let owed words drain, then allow for samples with no result
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] addr, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input int ticks, input int plimit,
                            input int blimit);
    write_reg(REG_MODE_SELECT,   {7'd0, mode});
    write_reg(REG_RELEASE_TICKS, 8'(ticks));
    write_reg(REG_PROGRAM_LIMIT, 8'(plimit));
    write_reg(REG_BANK_LIMIT,    8'(blimit));
    cur_ticks = ticks;
    settings_used++;
  endtask

  // Two-switch press and release; switches 3 and 4 carry random levels throughout
  task automatic dual_gesture(input int up_pct);
    int         kind;
    logic [3:0] lv;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 3)) send_word(4'($urandom));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      lv = 4'($urandom);
      if (kind < 10 + up_pct) lv[1:0] = 2'b01;      // switch 2 down
      else if (kind < 95)     lv[1:0] = 2'b10;      // switch 1 down
      else                    lv[1:0] = 2'b00;      // both down
      send_word(lv);
    end
    // now and then a bounce before the full release
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, cur_ticks)) send_word({2'($urandom), 2'b11});
      send_word({2'($urandom), 2'b00});
    end
    repeat (cur_ticks + $urandom_range(0, 2)) send_word({2'($urandom), 2'b11});
  endtask

  // Banked press and release: chords or a held pattern, then all released
  task automatic quad_gesture(input int up_pct);
    int         kind;
    logic [3:0] mask;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) send_word(4'($urandom));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      if (kind < 8 + up_pct) begin
        mask = CHORD_BANK_UP;
      end else if (kind < 18 + up_pct) begin
        mask = CHORD_BANK_DOWN;
      end else begin
        do mask = 4'($urandom_range(1, 15));
        while (mask == CHORD_BANK_DOWN || mask == CHORD_BANK_UP);
      end
      send_word(~mask);
    end
    repeat ($urandom_range(1, 2)) send_word(4'hF);
  endtask

  // Directed samples, levels active low
  localparam logic [3:0] DUAL_SEQ [14] = '{
    4'hE,                          // switch 1 at program 0: no step
    4'hF, 4'hF, 4'hF, 4'hF, 4'hF,  // release wait at the reset tick count
    4'hD, 4'hD,                    // switch 2 up to 1, held
    4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
    4'h0                           // all down: switch 1 wins, back to 0
  };
  localparam logic [3:0] QUAD_SEQ [12] = '{
    4'hC, 4'hF,                    // bank down at bank 0 stays put
    4'h3, 4'hF,                    // bank up to 1
    4'h5, 4'hF,                    // switches 2 and 4 held: slot 1
    4'h0, 4'hF,                    // all held: slot 0
    4'h7, 4'hF,                    // switch 4 only: slot 3
    4'hF, 4'hF                     // released with nothing held
  };

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset configuration, then banked basics
    foreach (DUAL_SEQ[i]) send_word(DUAL_SEQ[i]);
    settle();
    set_config(MODE_QUAD, 5, 20, 5);
    foreach (QUAD_SEQ[i]) send_word(QUAD_SEQ[i]);

    // Random: two-switch, full program range, quickest release
    settle();
    set_config(MODE_DUAL, 1, 127, 31);
    repeat (24) dual_gesture(70);

    // Banked, widest bank range, climbing towards the top bank
    settle();
    set_config(MODE_QUAD, 1, 127, 31);
    repeat (26) quad_gesture(50);

    // Bank limit lowered below the current bank
    settle();
    set_config(MODE_QUAD, 2, 127, 2);
    repeat (10) quad_gesture(25);

    // Program limit lowered below the current program
    settle();
    set_config(MODE_DUAL, 3, 4, 2);
    repeat (12) dual_gesture(40);

    // Zero release ticks and zero limits
    settle();
    set_config(MODE_DUAL, 0, 0, 0);
    repeat (10) dual_gesture(40);
    settle();
    set_config(MODE_QUAD, 0, 0, 0);
    repeat (10) quad_gesture(20);

    // Longest release wait
    settle();
    set_config(MODE_DUAL, 255, 127, 31);
    dual_gesture(60);

    // Back to the reset configuration, state carried over
    settle();
    set_config(MODE_DUAL, 5, 20, 5);
    repeat (6) dual_gesture(50);

    settle();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("Run covered %0d switch samples over %0d register settings,",
             samples_sent, settings_used);
    $display("with %0d program-change words checked against prediction.", programs_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
